// ===== src/dfi_pkg.sv =====
package dfi_pkg;

   localparam logic signed [15:0] K_0298 = 16'sd2446;
   localparam logic signed [15:0] K_0390 = 16'sd3196;
   localparam logic signed [15:0] K_0541 = 16'sd4433;
   localparam logic signed [15:0] K_0765 = 16'sd6270;
   localparam logic signed [15:0] K_0899 = 16'sd7373;
   localparam logic signed [15:0] K_1175 = 16'sd9633;
   localparam logic signed [15:0] K_1501 = 16'sd12299;
   localparam logic signed [15:0] K_1847 = 16'sd15137;
   localparam logic signed [15:0] K_1961 = 16'sd16069;
   localparam logic signed [15:0] K_2053 = 16'sd16819;
   localparam logic signed [15:0] K_2562 = 16'sd20995;
   localparam logic signed [15:0] K_3072 = 16'sd25172;

   typedef logic signed [15:0] word_type;
   typedef logic signed [31:0] acc_type;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_ROW,
      ST_COL,
      ST_DRAIN
   } state_type;

   // handoff from front to back: one full block is in the store
   typedef struct packed {
      logic vld;
   } blk_type;

   function automatic word_type w16(input acc_type v);
      return word_type'(v[15:0]);
   endfunction

   function automatic word_type narrow(input acc_type acc, input logic second);
      acc_type r;
      if (second) begin
         r = (acc + 32'sd16384) >>> 15;
      end else begin
         r = (acc + 32'sd1024) >>> 11;
      end
      return word_type'(r[15:0]);
   endfunction

endpackage

// ===== src/dct8x8_forward_islow_core.sv =====
// Accepts one sample per cycle while filling; 64 samples fill a sample memory.
// After the 64th sample, a row pass and then a column pass each run over 8 vectors
// (per vector: 8 serial reads, a pass through the 1-D unit, 8 serial writes).
// Coefficients then show one per pop (64 beats).
// The next block fills from the end of the row pass.
// Synchronous active-high reset clears counters and state; data stores are not cleared.
module dct8x8_forward_islow_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic signed [7:0]  req_sample,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [15:0] rsp_coefficient,
   output logic               rsp_last
);

   dfi_pkg::blk_type  blk;
   dfi_pkg::word_type bank_q;
   logic [5:0]        bank_addr;
   logic              take;

   dfi_front u_front (
      .clock(clock), .reset(reset), .req_push(req_push), .req_full(req_full),
      .req_sample(req_sample), .take(take), .blk(blk), .bank_addr(bank_addr),
      .bank_q(bank_q)
   );

   dfi_back u_back (
      .clock(clock), .reset(reset), .blk(blk), .bank_q(bank_q), .bank_addr(bank_addr),
      .take(take), .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_coefficient(rsp_coefficient), .rsp_last(rsp_last)
   );

endmodule

// ===== src/dfi_fdct8.sv =====
// one 1-D 8-point transform, two register stages (butterflies, then products)
module dfi_fdct8 (
   input  logic                clock,
   input  logic                second,
   input  dfi_pkg::word_type   x [8],
   output dfi_pkg::word_type   y [8]
);

   dfi_pkg::word_type t4_ff, t5_ff, t6_ff, t7_ff, e2_ff, e3_ff, s_ff, d_ff;
   dfi_pkg::word_type z1_ff, z2_ff, z3_ff, z4_ff, z5_ff, ez_ff;
   logic              sec_ff;
   dfi_pkg::acc_type  p_ff [12];
   dfi_pkg::word_type sa_in, da_in;

   always_ff @(posedge clock) begin
      dfi_pkg::word_type t0, t1, t2, t3, t4, t5, t6, t7, e0, e1, e2, e3;
      t0 = dfi_pkg::w16(32'(x[0]) + 32'(x[7]));
      t7 = dfi_pkg::w16(32'(x[0]) - 32'(x[7]));
      t1 = dfi_pkg::w16(32'(x[1]) + 32'(x[6]));
      t6 = dfi_pkg::w16(32'(x[1]) - 32'(x[6]));
      t2 = dfi_pkg::w16(32'(x[2]) + 32'(x[5]));
      t5 = dfi_pkg::w16(32'(x[2]) - 32'(x[5]));
      t3 = dfi_pkg::w16(32'(x[3]) + 32'(x[4]));
      t4 = dfi_pkg::w16(32'(x[3]) - 32'(x[4]));
      e0 = t0 + t3;
      e3 = t0 - t3;
      e1 = t1 + t2;
      e2 = t1 - t2;
      s_ff  <= e0 + e1;
      d_ff  <= e0 - e1;
      e2_ff <= e2;
      e3_ff <= e3;
      ez_ff <= e2 + e3;
      t4_ff <= t4;
      t5_ff <= t5;
      t6_ff <= t6;
      t7_ff <= t7;
      z1_ff <= t4 + t7;
      z2_ff <= t5 + t6;
      z3_ff <= t4 + t6;
      z4_ff <= t5 + t7;
      z5_ff <= (t4 + t6) + (t5 + t7);
      sec_ff <= second;
   end

   // stage 2: one product per multiplier, registered
   always_ff @(posedge clock) begin
      p_ff[0]  <= ez_ff * dfi_pkg::K_0541;
      p_ff[1]  <= e3_ff * dfi_pkg::K_0765;
      p_ff[2]  <= e2_ff * dfi_pkg::K_1847;
      p_ff[3]  <= z5_ff * dfi_pkg::K_1175;
      p_ff[4]  <= z1_ff * dfi_pkg::K_0899;
      p_ff[5]  <= z2_ff * dfi_pkg::K_2562;
      p_ff[6]  <= z3_ff * dfi_pkg::K_1961;
      p_ff[7]  <= z4_ff * dfi_pkg::K_0390;
      p_ff[8]  <= t4_ff * dfi_pkg::K_0298;
      p_ff[9]  <= t5_ff * dfi_pkg::K_2053;
      p_ff[10] <= t6_ff * dfi_pkg::K_3072;
      p_ff[11] <= t7_ff * dfi_pkg::K_1501;
   end

   dfi_pkg::word_type s2_ff, d2_ff;
   logic              sec2_ff;
   always_ff @(posedge clock) begin
      s2_ff   <= s_ff;
      d2_ff   <= d_ff;
      sec2_ff <= sec_ff;
   end

   assign sa_in = s2_ff + 16'sd2;
   assign da_in = d2_ff + 16'sd2;

   always_comb begin
      dfi_pkg::acc_type q1, q2, q3, q4;
      q1 = -p_ff[4];
      q2 = -p_ff[5];
      q3 = p_ff[3] - p_ff[6];
      q4 = p_ff[3] - p_ff[7];
      if (sec2_ff) begin
         y[0] = sa_in >>> 2;
         y[4] = da_in >>> 2;
      end else begin
         y[0] = s2_ff <<< 2;
         y[4] = d2_ff <<< 2;
      end
      y[2] = dfi_pkg::narrow(p_ff[0] + p_ff[1], sec2_ff);
      y[6] = dfi_pkg::narrow(p_ff[0] - p_ff[2], sec2_ff);
      y[7] = dfi_pkg::narrow(p_ff[8] + q1 + q3, sec2_ff);
      y[5] = dfi_pkg::narrow(p_ff[9] + q2 + q4, sec2_ff);
      y[3] = dfi_pkg::narrow(p_ff[10] + q2 + q3, sec2_ff);
      y[1] = dfi_pkg::narrow(p_ff[11] + q1 + q4, sec2_ff);
   end

endmodule

// ===== src/dfi_front.sv =====
// collects 64 samples into a sample memory; hands the full block over
module dfi_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic signed [7:0]  req_sample,
   input  logic               take,
   output dfi_pkg::blk_type   blk,
   input  logic [5:0]         bank_addr,
   output dfi_pkg::word_type  bank_q
);

   logic [5:0]        cnt_ff;
   logic              vld_ff;
   logic              beat;
   dfi_pkg::word_type bank_mem [64];

   assign req_full = vld_ff;
   assign beat     = req_push && !vld_ff;
   assign blk.vld  = vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         if (beat) begin
            cnt_ff <= cnt_ff + 6'd1;
         end
         if (beat && cnt_ff == 6'd63) begin
            vld_ff <= 1'b1;
         end else if (take) begin
            vld_ff <= 1'b0;
         end
      end
   end

   // one write per beat, one registered read per cycle for the back
   always_ff @(posedge clock) begin
      if (beat) begin
         bank_mem[cnt_ff] <= 16'(req_sample);
      end
      bank_q <= bank_mem[bank_addr];
   end

endmodule

// ===== src/dfi_back.sv =====
// row pass, column pass through one shared 1-D unit, then drain
// each vector: 8 serial reads, a pass through the unit, 8 serial writes
module dfi_back (
   input  logic               clock,
   input  logic               reset,
   input  dfi_pkg::blk_type   blk,
   input  dfi_pkg::word_type  bank_q,
   output logic [5:0]         bank_addr,
   output logic               take,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [15:0] rsp_coefficient,
   output logic               rsp_last
);

   localparam logic [4:0] StepLoad = 5'd8;
   localparam logic [4:0] StepWr   = 5'd11;
   localparam logic [4:0] StepLast = 5'd18;

   dfi_pkg::state_type state_ff, state_in;
   logic [4:0]        step_ff;
   logic [2:0]        vec_ff;
   logic [5:0]        out_ff, out_in;
   dfi_pkg::word_type work_mem [64];
   dfi_pkg::word_type work_q;
   dfi_pkg::word_type x_ff [8];
   dfi_pkg::word_type y [8];
   dfi_pkg::word_type ld_data;
   logic              second;
   logic              busy;
   logic              load_en;
   logic              wr_en;
   logic              step_end;
   logic              pass_done;
   logic [2:0]        ld_idx;
   logic [2:0]        wr_idx;
   logic [5:0]        rd_addr;
   logic [5:0]        wr_addr;

   dfi_fdct8 u_fdct8 (.clock(clock), .second(second), .x(x_ff), .y(y));

   assign busy      = (state_ff == dfi_pkg::ST_ROW) || (state_ff == dfi_pkg::ST_COL);
   assign second    = (state_ff == dfi_pkg::ST_COL);
   assign step_end  = (step_ff == StepLast);
   assign pass_done = step_end && (vec_ff == 3'd7);
   assign load_en   = busy && (step_ff >= 5'd1) && (step_ff <= StepLoad);
   assign ld_idx    = 3'(step_ff - 5'd1);
   assign ld_data   = second ? work_q : bank_q;
   assign wr_en     = busy && (step_ff >= StepWr);
   assign wr_idx    = 3'(step_ff - StepWr);
   assign wr_addr   = second ? {wr_idx, vec_ff} : {vec_ff, wr_idx};
   assign bank_addr = {vec_ff, step_ff[2:0]};
   assign out_in    = (!rsp_empty && rsp_pop) ? out_ff + 6'd1 : out_ff;
   // outside column loads, prefetch the coefficient at the next drain index
   assign rd_addr   = (second && step_ff < StepLoad) ? {step_ff[2:0], vec_ff} : out_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dfi_pkg::ST_FILL:  if (blk.vld) state_in = dfi_pkg::ST_ROW;
         dfi_pkg::ST_ROW:   if (pass_done) state_in = dfi_pkg::ST_COL;
         dfi_pkg::ST_COL:   if (pass_done) state_in = dfi_pkg::ST_DRAIN;
         dfi_pkg::ST_DRAIN: if (rsp_pop && out_ff == 6'd63) state_in = dfi_pkg::ST_FILL;
         default:           state_in = dfi_pkg::ST_FILL;
      endcase
   end

   always_comb begin
      take            = (state_ff == dfi_pkg::ST_ROW) && pass_done;
      rsp_empty       = (state_ff != dfi_pkg::ST_DRAIN);
      rsp_coefficient = work_q;
      rsp_last        = (out_ff == 6'd63);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dfi_pkg::ST_FILL;
         step_ff  <= '0;
         vec_ff   <= '0;
         out_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (busy) begin
            step_ff <= step_end ? 5'd0 : step_ff + 5'd1;
            if (step_end) begin
               vec_ff <= vec_ff + 3'd1;
            end
         end
         out_ff <= out_in;
      end
   end

   // hold the vector stable from the last load through the last write
   always_ff @(posedge clock) begin
      if (load_en) begin
         x_ff[ld_idx] <= ld_data;
      end
      if (wr_en) begin
         work_mem[wr_addr] <= y[wr_idx];
      end
      work_q <= work_mem[rd_addr];
   end

endmodule

// ===== src/dfi_checker.sv =====
module dfi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [15:0] rsp_coefficient,
   input logic        rsp_last
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("results after reset");
   a_reset_free: assert property (@(posedge clock) reset |=> !req_full)
      else $error("full after reset");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_coefficient)))
      else $error("result changed while waiting");
   a_last_end: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && rsp_last) |=> rsp_empty)
      else $error("results after last");

endmodule

bind dct8x8_forward_islow_core dfi_checker u_dfi_checker (
   .clock(clock), .reset(reset), .req_full(req_full), .rsp_empty(rsp_empty),
   .rsp_pop(rsp_pop), .rsp_coefficient(rsp_coefficient), .rsp_last(rsp_last)
);
